FILE: sv/plob_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plob_pkg: shared types and constants of the price-level order book
// Widths of request and result words, queue entry and side control types.
// ----------------------------------------------------------------------------
package plob_pkg;

	localparam int LEVELS   = 256;
	localparam int CNT_W    = $clog2(LEVELS + 1);
	localparam int PRICE_W  = 40;
	localparam int QTY_W    = 48;
	localparam int SUM_W    = 56;
	localparam int MID_W    = 41;
	localparam int SHARE_W  = 16;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);
	localparam logic [SHARE_W-1:0] SHARE_HALF = 16'd32768;

	localparam logic REQ_LEVEL = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_SET,
		OP_ERASE
	} op_t;

	typedef struct packed {
		logic               req_type;
		logic               side;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
	} req_t;

	typedef struct packed {
		logic [PRICE_W-1:0] top_bid;
		logic [PRICE_W-1:0] top_ask;
		logic [MID_W-1:0]   mid_half_ticks;
		logic [SUM_W-1:0]   bid_total;
		logic [SUM_W-1:0]   ask_total;
		logic [SHARE_W-1:0] bid_share;
		logic               side_full;
	} rsp_t;

	typedef struct packed {
		op_t                op;
		logic               side;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
	} job_t;

	typedef struct packed {
		logic               cmp;
		logic               upd;
		op_t                op;
		logic [PRICE_W-1:0] price;
		logic [QTY_W-1:0]   qty;
	} side_cmd_t;

	typedef struct packed {
		logic               nz;
		logic [PRICE_W-1:0] top;
		logic [SUM_W-1:0]   sum;
		logic               full;
	} side_stat_t;

endpackage
`default_nettype wire

FILE: sv/plob_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plob_front: request intake
// Classifies each request word into clear, set or erase and holds it in a
// short queue until the back end takes it.
// ----------------------------------------------------------------------------
module plob_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire plob_pkg::req_t req,
	output logic                q_valid,
	output plob_pkg::job_t      q_job,
	input  wire logic           pop
);

	plob_pkg::job_t                  ent_q [plob_pkg::QDEPTH];
	logic [plob_pkg::QPTR_W-1:0]     wr_q, rd_q;
	logic [plob_pkg::QCNT_W-1:0]     cnt_q;
	plob_pkg::job_t                  job_c;
	logic                            push;

	always_comb begin
		job_c.side  = req.side;
		job_c.price = req.price;
		job_c.qty   = req.qty;
		if (req.req_type == plob_pkg::REQ_CLEAR) begin
			job_c.op = plob_pkg::OP_CLEAR;
		end else if (req.qty == '0) begin
			job_c.op = plob_pkg::OP_ERASE;
		end else begin
			job_c.op = plob_pkg::OP_SET;
		end
	end

	assign busy    = (cnt_q == plob_pkg::QCNT_W'(plob_pkg::QDEPTH));
	assign push    = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign q_job   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= job_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop && q_valid) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + plob_pkg::QCNT_W'(push) - plob_pkg::QCNT_W'(pop && q_valid);
		end
	end

endmodule
`default_nettype wire

FILE: sv/plob_side.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plob_side: one sorted side of the book
// A row of level cells, best level in cell 0. Compare cycle marks the cells
// ahead of the request price and the matching cell; update cycle rewrites or shifts.
// ----------------------------------------------------------------------------
module plob_side (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  ask,
	input  wire plob_pkg::side_cmd_t   cmd,
	output plob_pkg::side_stat_t       stat
);

	logic [plob_pkg::PRICE_W-1:0] pr_q [plob_pkg::LEVELS];
	logic [plob_pkg::QTY_W-1:0]   sz_q [plob_pkg::LEVELS];
	logic [plob_pkg::PRICE_W-1:0] pr_d [plob_pkg::LEVELS];
	logic [plob_pkg::QTY_W-1:0]   sz_d [plob_pkg::LEVELS];
	logic [plob_pkg::LEVELS-1:0]  ahead_c, eq_c, ahead_s1, eq_s1;
	logic [plob_pkg::CNT_W-1:0]   count_q;
	logic [plob_pkg::SUM_W-1:0]   sum_q;
	logic                         full_q;
	logic [plob_pkg::QTY_W-1:0]   old_c;
	logic                         found, room, do_ins, do_set, do_era;

	always_comb begin
		for (int i = 0; i < plob_pkg::LEVELS; i++) begin
			ahead_c[i] = (plob_pkg::CNT_W'(i) < count_q)
				&& (ask ? (pr_q[i] < cmd.price) : (pr_q[i] > cmd.price));
			eq_c[i]    = (plob_pkg::CNT_W'(i) < count_q) && (pr_q[i] == cmd.price);
		end
	end

	always_comb begin
		old_c = '0;
		for (int i = 0; i < plob_pkg::LEVELS; i++) begin
			if (eq_s1[i]) begin
				old_c = old_c | sz_q[i];
			end
		end
	end

	assign found  = |eq_s1;
	assign room   = (count_q != plob_pkg::CNT_W'(plob_pkg::LEVELS));
	assign do_set = cmd.upd && (cmd.op == plob_pkg::OP_SET) && found;
	assign do_ins = cmd.upd && (cmd.op == plob_pkg::OP_SET) && !found && room;
	assign do_era = cmd.upd && (cmd.op == plob_pkg::OP_ERASE) && found;

	// shift right of the insert point, left from the erased cell
	always_comb begin
		for (int i = 0; i < plob_pkg::LEVELS; i++) begin
			pr_d[i] = pr_q[i];
			sz_d[i] = sz_q[i];
			if (do_set && eq_s1[i]) begin
				sz_d[i] = cmd.qty;
			end
			if (do_ins && !ahead_s1[i]) begin
				if (i == 0) begin
					pr_d[i] = cmd.price;
					sz_d[i] = cmd.qty;
				end else if (ahead_s1[(i+plob_pkg::LEVELS-1)%plob_pkg::LEVELS]) begin
					pr_d[i] = cmd.price;
					sz_d[i] = cmd.qty;
				end else begin
					pr_d[i] = pr_q[(i+plob_pkg::LEVELS-1)%plob_pkg::LEVELS];
					sz_d[i] = sz_q[(i+plob_pkg::LEVELS-1)%plob_pkg::LEVELS];
				end
			end
			if (do_era && !ahead_s1[i] && (i != plob_pkg::LEVELS-1)) begin
				pr_d[i] = pr_q[(i+1)%plob_pkg::LEVELS];
				sz_d[i] = sz_q[(i+1)%plob_pkg::LEVELS];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			ahead_s1 <= ahead_c;
			eq_s1    <= eq_c;
		end
		pr_q <= pr_d;
		sz_q <= sz_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			full_q  <= 1'b0;
		end else if (cmd.upd) begin
			full_q <= (cmd.op == plob_pkg::OP_SET) && !found && !room;
			if (cmd.op == plob_pkg::OP_CLEAR) begin
				count_q <= '0;
				sum_q   <= '0;
			end else if (do_ins) begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + plob_pkg::SUM_W'(cmd.qty);
			end else if (do_set) begin
				sum_q <= sum_q - plob_pkg::SUM_W'(old_c) + plob_pkg::SUM_W'(cmd.qty);
			end else if (do_era) begin
				count_q <= count_q - 1'b1;
				sum_q   <= sum_q - plob_pkg::SUM_W'(old_c);
			end
		end
	end

	assign stat.nz   = (count_q != '0);
	assign stat.top  = pr_q[0];
	assign stat.sum  = sum_q;
	assign stat.full = full_q;

endmodule
`default_nettype wire

FILE: sv/plob_share.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plob_share: bid share divider
// Scales both totals below 2^47, then divides with rounding by restoring
// division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plob_share (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [plob_pkg::SUM_W-1:0]    b,
	input  wire logic [plob_pkg::SUM_W-1:0]    a,
	output logic                               done,
	output logic [plob_pkg::SHARE_W-1:0]       q
);

	typedef enum logic [1:0] {ST_IDLE, ST_NORM, ST_RUN} state_t;

	state_t                    state_q;
	logic [56:0]               t_q;
	logic [55:0]               b_q;
	logic [62:0]               r_q;
	logic [61:0]               d_q;
	logic [3:0]                cnt_q;
	logic [plob_pkg::SHARE_W-1:0] q_q;
	logic                      done_q;
	logic [56:0]               t_c;
	logic [3:0]                s_c;
	logic [46:0]               tn_c, bn_c;
	logic                      ge_c;

	assign t_c = {1'b0, b} + {1'b0, a};

	always_comb begin
		s_c = '0;
		for (int k = 0; k < 10; k++) begin
			if (t_q[47+k]) begin
				s_c = 4'(k + 1);
			end
		end
		tn_c = 47'(t_q >> s_c);
		bn_c = 47'(b_q >> s_c);
	end

	assign ge_c = (r_q >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						t_q <= t_c;
						b_q <= b;
						if (t_c == '0) begin
							q_q    <= plob_pkg::SHARE_HALF;
							done_q <= 1'b1;
						end else begin
							state_q <= ST_NORM;
						end
					end
				end
				ST_NORM: begin
					r_q     <= {bn_c, 16'd0} - 63'(bn_c) + 63'(tn_c[46:1]);
					d_q     <= {tn_c, 15'd0};
					q_q     <= '0;
					cnt_q   <= 4'd15;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (ge_c) begin
						r_q <= r_q - {1'b0, d_q};
					end
					q_q <= {q_q[plob_pkg::SHARE_W-2:0], ge_c};
					d_q <= d_q >> 1;
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign q    = q_q;

endmodule
`default_nettype wire

FILE: sv/plob_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plob_back: request execution
// Takes one queued word at a time, runs it through its side table (both for
// a clear), then the share divider, and strobes out the result word.
// ----------------------------------------------------------------------------
module plob_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire plob_pkg::job_t q_job,
	output logic                pop,
	output logic                done,
	output plob_pkg::rsp_t      rsp
);

	typedef enum logic [2:0] {ST_IDLE, ST_CMP, ST_UPD, ST_SHARE, ST_WAIT} state_t;

	state_t               state_q;
	plob_pkg::job_t       job_q;
	logic                 done_q;
	plob_pkg::rsp_t       rsp_q;
	plob_pkg::side_cmd_t  bid_cmd, ask_cmd;
	plob_pkg::side_stat_t bid_st, ask_st;
	logic                 sh_start, sh_done;
	logic [plob_pkg::SHARE_W-1:0] sh_q;
	logic                 hit_bid, hit_ask;

	assign hit_bid = (job_q.op == plob_pkg::OP_CLEAR) || !job_q.side;
	assign hit_ask = (job_q.op == plob_pkg::OP_CLEAR) || job_q.side;

	always_comb begin
		bid_cmd.op    = job_q.op;
		bid_cmd.price = job_q.price;
		bid_cmd.qty   = job_q.qty;
		bid_cmd.cmp   = (state_q == ST_CMP) && hit_bid;
		bid_cmd.upd   = (state_q == ST_UPD) && hit_bid;
		ask_cmd       = bid_cmd;
		ask_cmd.cmp   = (state_q == ST_CMP) && hit_ask;
		ask_cmd.upd   = (state_q == ST_UPD) && hit_ask;
	end

	plob_side u_bid (.clk(clk), .arst_n(arst_n), .ask(1'b0), .cmd(bid_cmd), .stat(bid_st));
	plob_side u_ask (.clk(clk), .arst_n(arst_n), .ask(1'b1), .cmd(ask_cmd), .stat(ask_st));

	assign sh_start = (state_q == ST_SHARE);

	plob_share u_share (
		.clk(clk), .arst_n(arst_n), .start(sh_start),
		.b(bid_st.sum), .a(ask_st.sum), .done(sh_done), .q(sh_q)
	);

	assign pop = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						job_q   <= q_job;
						state_q <= ST_CMP;
					end
				end
				ST_CMP:   state_q <= ST_UPD;
				ST_UPD:   state_q <= ST_SHARE;
				ST_SHARE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (sh_done) begin
						rsp_q.top_bid   <= bid_st.nz ? bid_st.top : '0;
						rsp_q.top_ask   <= ask_st.nz ? ask_st.top : '0;
						rsp_q.mid_half_ticks <= (bid_st.nz && ask_st.nz)
							? ({1'b0, bid_st.top} + {1'b0, ask_st.top}) : '0;
						rsp_q.bid_total <= bid_st.sum;
						rsp_q.ask_total <= ask_st.sum;
						rsp_q.bid_share <= sh_q;
						rsp_q.side_full <= (job_q.op == plob_pkg::OP_SET)
							&& (job_q.side ? ask_st.full : bid_st.full);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

FILE: sv/price_level_order_book_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// price_level_order_book_top: two-sided price-level order book
// Channel   Ports              Handshake
// request   req (req_t)        taken at clk when start && !busy
// result    rsp (rsp_t)        valid for one cycle while done is high
//
// Each word passes from the queue through a pop, a compare and a shift
// step in the level cells, then the share divider (scale, then one quotient
// bit per cycle, 16 bits). With both totals zero the divider skips the
// scale and the division and answers with SHARE_HALF.
// Up to two words wait in the intake queue; busy is high while it is full.
// Reset empties both sides and the queue; no clearing pass is needed.
// The receiver cannot stall: every result is shown for one cycle only.
// ----------------------------------------------------------------------------
module price_level_order_book_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire plob_pkg::req_t req,
	output logic                done,
	output plob_pkg::rsp_t      rsp
);

	logic           q_valid, pop;
	plob_pkg::job_t q_job;

	plob_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.q_valid(q_valid), .q_job(q_job), .pop(pop)
	);

	plob_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_job(q_job),
		.pop(pop), .done(done), .rsp(rsp)
	);

`ifndef NO_ASSERTIONS
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("back-to-back results");

	a_empty_share: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.bid_total == '0 && rsp.ask_total == '0)
		|-> (rsp.bid_share == plob_pkg::SHARE_HALF)) else $error("empty share wrong");

	a_busy_queue: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> q_valid) else $error("busy with empty queue");
`endif

endmodule
`default_nettype wire
